>>> hdl/ttm_pkg.sv
// ----------------------------------------------------------------------------
// ttm_pkg
// Shared types and constants for the track table manager.
// ----------------------------------------------------------------------------
package ttm_pkg;

    localparam int MAX_TRACKS_DEF = 32;
    localparam int COORD_BITS_DEF = 16;

    localparam int ID_W       = 16;
    localparam int GATE_W     = 16;
    localparam int CNT8_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_GATE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONFIRM = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DROP    = 2'd2;

    localparam logic [GATE_W-1:0] GATE_RST    = 16'd500;
    localparam logic [CNT8_W-1:0] CONFIRM_RST = 8'd3;
    localparam logic [CNT8_W-1:0] DROP_RST    = 8'd3;
    localparam logic [CNT8_W-1:0] CNT8_MAX    = 8'hFF;

    // input command codes
    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_EOF    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       latch;      // capture input transaction, reset pointers
        logic       rd;         // read slot at pointer
        logic       mul_en;     // square one axis difference
        logic [1:0] axis;       // 0 = x, 1 = y, 2 = z
        logic       update;     // matched: rewrite slot at pointer
        logic       step;       // advance pointer
        logic       append;     // new slot at end of table
        logic       set_drop;   // table full
        logic       c_write;    // compaction: keep slot at write pointer
        logic       c_done;     // compaction finished
        logic       load_out;   // emit the slot just read
        logic       load_mark;  // emit the empty marker
        logic       load_pass;  // emit the pass-through record
        logic       clr_drop;   // frame closed
    } ttm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cmd_eof;
        logic passthru;
        logic at_end;
        logic full;
        logic hit;
        logic conf;
        logic is_last;
        logic n_zero;
        logic out_free;
    } ttm_stat_t;

endpackage

>>> hdl/track_table_manager_top.sv
// ----------------------------------------------------------------------------
// track_table_manager_top
// Ordered track table with distance gating, hit confirmation and miss removal.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_       | in        | s_tvalid/s_tready  | s_tdata, s_tuser (command)
//  m_       | out       | m_tvalid/m_tready  | m_tdata, m_tuser, m_tlast
//  cfg_     | in        | cfg_wr_en          | cfg_addr, cfg_wdata
//
//  A detection walks the table one slot at a time through the slot memory's
//  single read port and a shared multiplier. End of frame compacts the
//  table slot by slot, then scans the slots for emission; output stalls
//  hold the sequencer. Reset is synchronous, active low, and leaves an
//  empty table with no clearing pass.
// ----------------------------------------------------------------------------
module track_table_manager_top #(
    parameter int MAX_TRACKS = ttm_pkg::MAX_TRACKS_DEF,
    parameter int COORD_BITS = ttm_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ttm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ttm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, pos_z, source_id
    input  logic [((3*COORD_BITS+ttm_pkg::ID_W+7)/8)*8-1:0] s_tdata,
    // command
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // track_id, out_x, out_y, out_z
    output logic [((3*COORD_BITS+ttm_pkg::ID_W+7)/8)*8-1:0] m_tdata,
    // valid_res, overflowed
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    import ttm_pkg::*;

    localparam int TD_W  = ((3*COORD_BITS+ID_W+7)/8)*8;
    localparam int PAD_W = TD_W - (3*COORD_BITS + ID_W);

    ttm_cmd_t  cmd;
    ttm_stat_t stat;

    logic [ID_W-1:0]              out_id;
    logic signed [COORD_BITS-1:0] out_x, out_y, out_z;
    logic                         out_valid, out_ovf;

    ttm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttm_datapath #(
        .MAX_TRACKS (MAX_TRACKS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_tuser),
        .in_x      (s_tdata[COORD_BITS-1:0]),
        .in_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_z      (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_src    (s_tdata[3*COORD_BITS+ID_W-1:3*COORD_BITS]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_id    (out_id),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_valid (out_valid),
        .out_last  (m_tlast),
        .out_ovf   (out_ovf),
        .cmd       (cmd),
        .stat      (stat)
    );

    // result packing, first field lowest
    assign m_tdata = TD_W'({out_z, out_y, out_x, out_id});
    assign m_tuser = {out_ovf, out_valid};

    // pad bits of s_tdata carry nothing
    if (PAD_W > 0) begin : g_pad
        logic unused_pad;
        assign unused_pad = ^s_tdata[TD_W-1:TD_W-PAD_W];
    end

endmodule

>>> hdl/ttm_ctrl.sv
// ----------------------------------------------------------------------------
// ttm_ctrl
// Sequencer for match scan, end-of-frame compaction and emission.
// ----------------------------------------------------------------------------
module ttm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ttm_pkg::ttm_stat_t stat,
    output ttm_pkg::ttm_cmd_t  cmd
);
    import ttm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PASS,
        ST_SCHK, ST_SRD, ST_AX0, ST_AX1, ST_AX2, ST_SCMP,
        ST_CCHK, ST_CRD, ST_CWR,
        ST_ERD, ST_EOUT, ST_EMARK
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    if (stat.cmd_eof)
                        state_next = ST_CCHK;
                    else if (stat.passthru)
                        state_next = ST_PASS;
                    else
                        state_next = ST_SCHK;
                end
            end
            ST_PASS: begin
                if (stat.out_free) begin
                    cmd.load_pass = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCHK: begin
                if (stat.at_end) begin
                    if (stat.full)
                        cmd.set_drop = 1'b1;
                    else
                        cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SRD;
                end
            end
            ST_SRD: begin
                cmd.rd     = 1'b1;
                state_next = ST_AX0;
            end
            ST_AX0: begin
                cmd.mul_en = 1'b1;
                cmd.axis   = 2'd0;
                state_next = ST_AX1;
            end
            ST_AX1: begin
                cmd.mul_en = 1'b1;
                cmd.axis   = 2'd1;
                state_next = ST_AX2;
            end
            ST_AX2: begin
                cmd.mul_en = 1'b1;
                cmd.axis   = 2'd2;
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                if (stat.hit) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_SCHK;
                end
            end
            ST_CCHK: begin
                if (stat.at_end) begin
                    cmd.c_done = 1'b1;
                    state_next = stat.n_zero ? ST_EMARK : ST_ERD;
                end else begin
                    state_next = ST_CRD;
                end
            end
            ST_CRD: begin
                cmd.rd     = 1'b1;
                state_next = ST_CWR;
            end
            ST_CWR: begin
                cmd.c_write = 1'b1;
                cmd.step    = 1'b1;
                state_next  = ST_CCHK;
            end
            ST_ERD: begin
                cmd.rd     = 1'b1;
                state_next = ST_EOUT;
            end
            ST_EOUT: begin
                if (!stat.conf) begin
                    cmd.step   = 1'b1;
                    state_next = ST_ERD;
                end else if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.step     = 1'b1;
                    if (stat.is_last) begin
                        cmd.clr_drop = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_ERD;
                    end
                end
            end
            ST_EMARK: begin
                if (stat.out_free) begin
                    cmd.load_mark = 1'b1;
                    cmd.clr_drop  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/ttm_datapath.sv
// ----------------------------------------------------------------------------
// ttm_datapath
// Slot memory, distance unit, counters, configuration and output register.
// ----------------------------------------------------------------------------
module ttm_datapath #(
    parameter int MAX_TRACKS = ttm_pkg::MAX_TRACKS_DEF,
    parameter int COORD_BITS = ttm_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [ttm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ttm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input transaction fields
    input  logic                                in_cmd,
    input  logic signed [COORD_BITS-1:0]        in_x,
    input  logic signed [COORD_BITS-1:0]        in_y,
    input  logic signed [COORD_BITS-1:0]        in_z,
    input  logic [ttm_pkg::ID_W-1:0]            in_src,
    // result register
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [ttm_pkg::ID_W-1:0]            out_id,
    output logic signed [COORD_BITS-1:0]        out_x,
    output logic signed [COORD_BITS-1:0]        out_y,
    output logic signed [COORD_BITS-1:0]        out_z,
    output logic                                out_valid,
    output logic                                out_last,
    output logic                                out_ovf,
    // controller link
    input  ttm_pkg::ttm_cmd_t                   cmd,
    output ttm_pkg::ttm_stat_t                  stat
);
    import ttm_pkg::*;

    localparam int IDX_W = $clog2(MAX_TRACKS);
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam int DIF_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * DIF_W;
    localparam int ACC_W = SQ_W + 2;
    localparam int G2_W  = 2 * GATE_W;
    localparam int CMP_W = (ACC_W > G2_W) ? ACC_W : G2_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TRACKS);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         conf;
        logic [ID_W-1:0]              id;
        logic [CNT8_W-1:0]            hits;
        logic [CNT8_W-1:0]            misses;
        logic                         seen;
    } slot_t;

    // configuration registers
    logic [GATE_W-1:0] gate_reg;
    logic [CNT8_W-1:0] confirm_reg, drop_reg;
    logic [G2_W-1:0]   gate2_reg;

    // control counters
    logic [CNT_W-1:0] cnt_reg, ptr_reg, wptr_reg, ncf_reg, k_reg;
    logic [ID_W-1:0]  id_ctr_reg;
    logic             drop_reg_flag;

    // latched transaction
    logic signed [COORD_BITS-1:0] det_x_reg, det_y_reg, det_z_reg;
    logic [ID_W-1:0]              det_src_reg;

    // memory and read data
    slot_t mem [MAX_TRACKS];
    slot_t rd_reg;

    // distance unit
    logic signed [DIF_W-1:0] diff;
    logic signed [SQ_W-1:0]  prod;
    logic [SQ_W-1:0]         sq_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [CMP_W-1:0]        dist_sum;

    // output register
    logic m_tvalid_reg;

    logic             out_free;
    logic [CNT8_W-1:0] hits_inc, miss_inc, miss_new;
    logic             promo_upd, promo_app, keep;
    slot_t            wr_data;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;

    assign out_free = !m_tvalid_reg || m_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg    <= GATE_RST;
            confirm_reg <= CONFIRM_RST;
            drop_reg    <= DROP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_GATE:    gate_reg    <= cfg_wdata[GATE_W-1:0];
                CFG_CONFIRM: confirm_reg <= cfg_wdata[CNT8_W-1:0];
                CFG_DROP:    drop_reg    <= cfg_wdata[CNT8_W-1:0];
                default:     ;
            endcase
        end
    end

    // squared gate, settles while idle
    always_ff @(posedge aclk) begin
        gate2_reg <= gate_reg * gate_reg;
    end

    // axis difference and squaring, accumulated over the three axes
    always_comb begin
        case (cmd.axis)
            2'd0:    diff = DIF_W'(det_x_reg) - DIF_W'(rd_reg.x);
            2'd1:    diff = DIF_W'(det_y_reg) - DIF_W'(rd_reg.y);
            default: diff = DIF_W'(det_z_reg) - DIF_W'(rd_reg.z);
        endcase
    end

    assign prod = diff * diff;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            sq_reg  <= prod;
            acc_reg <= (cmd.axis == 2'd0) ? '0 : acc_reg + ACC_W'(sq_reg);
        end
    end

    assign dist_sum = CMP_W'(acc_reg) + CMP_W'(sq_reg);

    // slot update values
    assign hits_inc  = (rd_reg.hits == CNT8_MAX) ? CNT8_MAX : rd_reg.hits + 8'd1;
    assign miss_inc  = (rd_reg.misses == CNT8_MAX) ? CNT8_MAX : rd_reg.misses + 8'd1;
    assign miss_new  = rd_reg.seen ? rd_reg.misses : miss_inc;
    assign keep      = rd_reg.seen || (miss_new < drop_reg);
    assign promo_upd = !rd_reg.conf && (hits_inc >= confirm_reg);
    assign promo_app = (confirm_reg <= 8'd1);

    // memory write selection
    always_comb begin
        wr_data = rd_reg;
        wr_addr = ptr_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        if (cmd.update) begin
            wr_en          = 1'b1;
            wr_data.x      = det_x_reg;
            wr_data.y      = det_y_reg;
            wr_data.z      = det_z_reg;
            wr_data.hits   = hits_inc;
            wr_data.misses = '0;
            wr_data.seen   = 1'b1;
            if (promo_upd) begin
                wr_data.conf = 1'b1;
                wr_data.id   = id_ctr_reg;
            end
        end else if (cmd.append) begin
            wr_en          = 1'b1;
            wr_data.x      = det_x_reg;
            wr_data.y      = det_y_reg;
            wr_data.z      = det_z_reg;
            wr_data.conf   = promo_app;
            wr_data.id     = promo_app ? id_ctr_reg : '0;
            wr_data.hits   = 8'd1;
            wr_data.misses = '0;
            wr_data.seen   = 1'b1;
        end else if (cmd.c_write && keep) begin
            wr_en          = 1'b1;
            wr_addr        = wptr_reg[IDX_W-1:0];
            wr_data.misses = miss_new;
            wr_data.seen   = 1'b0;
        end
    end

    // slot memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd)
            rd_reg <= mem[ptr_reg[IDX_W-1:0]];
    end

    // latched transaction fields
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            det_x_reg   <= in_x;
            det_y_reg   <= in_y;
            det_z_reg   <= in_z;
            det_src_reg <= in_src;
        end
    end

    // counters, id counter and drop flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            wptr_reg      <= '0;
            ncf_reg       <= '0;
            k_reg         <= '0;
            id_ctr_reg    <= '0;
            drop_reg_flag <= 1'b0;
        end else begin
            if (cmd.latch) begin
                ptr_reg  <= '0;
                wptr_reg <= '0;
                ncf_reg  <= '0;
            end
            if (cmd.step)
                ptr_reg <= ptr_reg + 1'b1;
            if (cmd.append)
                cnt_reg <= cnt_reg + 1'b1;
            if ((cmd.update && promo_upd) || (cmd.append && promo_app))
                id_ctr_reg <= id_ctr_reg + 1'b1;
            if (cmd.set_drop)
                drop_reg_flag <= 1'b1;
            if (cmd.c_write && keep) begin
                wptr_reg <= wptr_reg + 1'b1;
                if (rd_reg.conf)
                    ncf_reg <= ncf_reg + 1'b1;
            end
            if (cmd.c_done) begin
                cnt_reg <= wptr_reg;
                ptr_reg <= '0;
                k_reg   <= '0;
            end
            if (cmd.load_out)
                k_reg <= k_reg + 1'b1;
            if (cmd.clr_drop)
                drop_reg_flag <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out || cmd.load_mark || cmd.load_pass) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_id    <= rd_reg.id;
            out_x     <= rd_reg.x;
            out_y     <= rd_reg.y;
            out_z     <= rd_reg.z;
            out_valid <= 1'b1;
            out_last  <= (k_reg + 1'b1 == ncf_reg);
            out_ovf   <= drop_reg_flag;
        end else if (cmd.load_mark) begin
            out_id    <= '0;
            out_x     <= '0;
            out_y     <= '0;
            out_z     <= '0;
            out_valid <= 1'b0;
            out_last  <= 1'b1;
            out_ovf   <= drop_reg_flag;
        end else if (cmd.load_pass) begin
            out_id    <= det_src_reg;
            out_x     <= det_x_reg;
            out_y     <= det_y_reg;
            out_z     <= det_z_reg;
            out_valid <= 1'b1;
            out_last  <= 1'b1;
            out_ovf   <= drop_reg_flag;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // status to controller
    assign stat.cmd_eof  = (in_cmd == CMD_EOF);
    assign stat.passthru = (confirm_reg == '0);
    assign stat.at_end   = (ptr_reg == cnt_reg);
    assign stat.full     = (cnt_reg == FULL_CNT);
    assign stat.hit      = (dist_sum < CMP_W'(gate2_reg));
    assign stat.conf     = rd_reg.conf;
    assign stat.is_last  = (k_reg + 1'b1 == ncf_reg);
    assign stat.n_zero   = (ncf_reg == '0);
    assign stat.out_free = out_free;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("slot count beyond table depth");
    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |-> (cnt_reg < FULL_CNT) && (ptr_reg == cnt_reg))
        else $error("append without room or off the table end");
    a_wptr_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.c_write |-> wptr_reg <= ptr_reg)
        else $error("compaction write overtook read");
    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> k_reg < ncf_reg)
        else $error("more records emitted than confirmed slots");
`endif

endmodule

>>> test/track_table_manager_top_test.sv
// ----------------------------------------------------------------------------
// track_table_manager_top_test
// Self-checking bench for the track table manager: streams detections and
// end-of-frame commands, predicts the track records with a model of the
// table, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module track_table_manager_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ttm_pkg::*;

    localparam int NSLOT = 32;

    typedef struct {
        logic [15:0] track_id;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic        valid_res;
        logic        last;
        logic        overflowed;
    } track_rec_t;

    // Table model plus queue of pending track records
    class track_board;
        logic [15:0] gate;
        logic [7:0]  confirm;
        logic [7:0]  drop;
        bit          used[NSLOT];
        logic signed [15:0] sx[NSLOT], sy[NSLOT], sz[NSLOT];
        bit          conf[NSLOT];
        logic [15:0] tid[NSLOT];
        logic [7:0]  hits[NSLOT], miss[NSLOT];
        bit          seen[NSLOT];
        logic [15:0] next_id;
        bit          dropped;
        track_rec_t  pending[$];
        int          errors;

        function new();
            gate = GATE_RST; confirm = CONFIRM_RST; drop = DROP_RST;
            foreach (used[i]) begin
                used[i] = 0; seen[i] = 0;
            end
            next_id = 0; dropped = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            case (idx)
                CFG_GATE:    gate = v;
                CFG_CONFIRM: confirm = v[7:0];
                CFG_DROP:    drop = v[7:0];
                default: ;
            endcase
        endfunction

        function void promote(int i);
            if (!conf[i] && hits[i] >= confirm) begin
                conf[i] = 1; tid[i] = next_id; next_id++;
            end
        endfunction

        function void push(logic [15:0] id, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, bit v, bit l);
            track_rec_t r;
            r.track_id = id; r.px = x; r.py = y; r.pz = z;
            r.valid_res = v; r.last = l; r.overflowed = dropped;
            pending.insert(pending.size(), r);
        endfunction

        // note one accepted input transaction
        function void note_input(bit cmd, logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z, logic [15:0] src);
            longint dx, dy, dz, g2;
            int i, w, n, k;
            if (cmd == CMD_EOF) begin
                w = 0;
                for (i = 0; i < NSLOT; i++) begin
                    if (!used[i]) continue;
                    if (!seen[i]) begin
                        if (miss[i] != 8'hFF) miss[i]++;
                        if (miss[i] >= drop) continue;
                    end
                    sx[w] = sx[i]; sy[w] = sy[i]; sz[w] = sz[i];
                    conf[w] = conf[i]; tid[w] = tid[i]; hits[w] = hits[i];
                    miss[w] = miss[i]; seen[w] = 0; used[w] = 1;
                    w++;
                end
                for (i = w; i < NSLOT; i++) begin
                    used[i] = 0; seen[i] = 0;
                end
                n = 0;
                for (i = 0; i < w; i++) if (conf[i]) n++;
                k = 0;
                for (i = 0; i < w; i++) begin
                    if (!conf[i]) continue;
                    push(tid[i], sx[i], sy[i], sz[i], 1, k == n - 1);
                    k++;
                end
                if (k == 0) push(0, 0, 0, 0, 0, 1);
                dropped = 0;
                return;
            end
            if (confirm == 0) begin
                push(src, x, y, z, 1, 1);
                return;
            end
            g2 = longint'(gate) * longint'(gate);
            for (i = 0; i < NSLOT; i++) begin
                if (!used[i]) break;
                dx = longint'(x) - longint'(sx[i]);
                dy = longint'(y) - longint'(sy[i]);
                dz = longint'(z) - longint'(sz[i]);
                if (dx*dx + dy*dy + dz*dz < g2) begin
                    sx[i] = x; sy[i] = y; sz[i] = z;
                    if (hits[i] != 8'hFF) hits[i]++;
                    miss[i] = 0; seen[i] = 1;
                    promote(i);
                    return;
                end
            end
            if (i >= NSLOT) begin
                dropped = 1;
                return;
            end
            used[i] = 1; sx[i] = x; sy[i] = y; sz[i] = z; conf[i] = 0; tid[i] = 0;
            hits[i] = 1; miss[i] = 0; seen[i] = 1;
            promote(i);
        endfunction

        // compare one result transaction with the oldest pending record
        function void check_result(track_rec_t got);
            track_rec_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result id=%h", $realtime, got.track_id);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.track_id !== e.track_id)
                $display("%0t: track_id exp %h got %h", $realtime, e.track_id, got.track_id);
            if (got.px !== e.px) $display("%0t: x exp %h got %h", $realtime, e.px, got.px);
            if (got.py !== e.py) $display("%0t: y exp %h got %h", $realtime, e.py, got.py);
            if (got.pz !== e.pz) $display("%0t: z exp %h got %h", $realtime, e.pz, got.pz);
            if (got.valid_res !== e.valid_res)
                $display("%0t: valid exp %b got %b", $realtime, e.valid_res, got.valid_res);
            if (got.last !== e.last)
                $display("%0t: last exp %b got %b", $realtime, e.last, got.last);
            if (got.overflowed !== e.overflowed)
                $display("%0t: ovf exp %b got %b", $realtime, e.overflowed, got.overflowed);
            if (got.track_id !== e.track_id || got.px !== e.px || got.py !== e.py ||
                got.pz !== e.pz || got.valid_res !== e.valid_res ||
                got.last !== e.last || got.overflowed !== e.overflowed)
                errors++;
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int send_idle = 35;
    int recv_idle = 87;

    track_board board = new();

    track_table_manager_top i_dut (.*);

    initial forever #4 aclk = ~aclk;

    // receiver: random stalls, check each result transaction
    always @(posedge aclk) begin
        track_rec_t r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                r.track_id = m_tdata[15:0]; r.px = m_tdata[31:16];
                r.py = m_tdata[47:32]; r.pz = m_tdata[63:48];
                r.valid_res = m_tuser[0]; r.overflowed = m_tuser[1]; r.last = m_tlast;
                board.check_result(r);
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1; cfg_addr <= idx; cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        board.set_reg(idx, v);
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send(bit cmd, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                        logic [15:0] src);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_tvalid <= 1; s_tuser <= cmd; s_tdata <= {src, z, y, x};
        do @(posedge aclk); while (!s_tready);
        board.note_input(cmd, x, y, z, src);
    endtask

    // wait until every record has come out, then let the block settle
    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic rand_frame(int nd, int spread, int base);
        int j;
        logic [15:0] c;
        for (j = 0; j < nd; j++) begin
            c = 16'(base + $urandom_range(4) * 600 + $urandom_range(spread));
            send(CMD_DETECT, c, c + 16'd7, c - 16'd3, 16'($urandom));
        end
        send(CMD_EOF, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        int p, f, cnt;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty frame, extremes, confirmation, removal
        send(CMD_EOF, 0, 0, 0, 0);
        send(CMD_DETECT, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send(CMD_DETECT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        send(CMD_DETECT, 16'h8001, 16'h8000, 16'h8000, 1);
        send(CMD_DETECT, 16'h8002, 16'h8000, 16'h8000, 2);
        send(CMD_EOF, 0, 0, 0, 0);
        send(CMD_DETECT, 16'h8002, 16'h8000, 16'h8000, 2);
        send(CMD_EOF, 0, 0, 0, 0);
        send(CMD_EOF, 0, 0, 0, 0);
        send(CMD_EOF, 0, 0, 0, 0);
        send(CMD_EOF, 0, 0, 0, 0);
        drain();
        // pass-through, then table overflow with zero gate
        write_reg(CFG_CONFIRM, 0);
        send(CMD_DETECT, 16'h1234, 16'hFFFF, 16'h0000, 16'hABCD);
        send(CMD_DETECT, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h5555);
        send(CMD_EOF, 0, 0, 0, 0);
        drain();
        write_reg(CFG_CONFIRM, 1);
        write_reg(CFG_GATE, 0);
        write_reg(CFG_DROP, 0);
        for (cnt = 0; cnt < 34; cnt++) send(CMD_DETECT, 16'(cnt), 0, 0, 0);
        send(CMD_EOF, 0, 0, 0, 0);
        send(CMD_EOF, 0, 0, 0, 0);
        drain();

        // random phases over settings and idle mixes
        for (p = 0; p < 9; p++) begin
            if (p == 3) begin send_idle = 87; recv_idle = 35; end
            if (p == 6) begin send_idle = 0; recv_idle = 0; end
            case (p % 3)
                0: begin write_reg(CFG_GATE, 500); write_reg(CFG_CONFIRM, 3);
                         write_reg(CFG_DROP, 3); end
                1: begin write_reg(CFG_GATE, 16'hFFFF); write_reg(CFG_CONFIRM, 255);
                         write_reg(CFG_DROP, 255); end
                default: begin write_reg(CFG_GATE, 16'($urandom_range(200, 50)));
                         write_reg(CFG_CONFIRM, 16'($urandom_range(4))); // 0 = pass-through
                         write_reg(CFG_DROP, 16'($urandom_range(2))); end
            endcase
            for (f = 0; f < 9; f++)
                if ($urandom_range(9) == 0)
                    rand_frame(3, 65535, 0);  // noise: any position
                else
                    rand_frame($urandom_range(8, 1), 80, $urandom_range(9) * 4000);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
